// File: rtl/rr_pkg.sv
package rr_pkg;

  // width of numerator and denominator
  localparam int DATA_WIDTH = 32;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // input item
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
  } rr_in_t;

  // result item
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] reduced_numerator;
    logic        [DATA_WIDTH-2:0] reduced_denominator;
    logic        [1:0]            status;
  } rr_out_t;

endpackage

// File: rtl/rational_reduce.sv
// Reduces a signed fraction to lowest terms with a positive denominator.
// Input channel: in_valid_i / in_stall_o carry numerator and denominator;
// a transfer happens on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry the reduced numerator,
// the reduced denominator and a status (ok, zero denominator, overflow).
// Exactly one result leaves for every input transfer.
// One restoring divider, one quotient bit per cycle, does all arithmetic:
// every Euclid remainder step and the two final divisions by the gcd.
// An item needs k + 2 divisions, k being the number of Euclid remainder
// steps (up to about 46 for 32-bit operands). A zero denominator skips
// the divider and goes straight to the result write. Input stall stays
// high from a transfer until its result has been written to the
// output register. The output register lets the next item start while
// a result waits; a stalled receiver holds the result, and a finished
// item waits in place until the register frees up.
// Reset clears the sequencer and the output valid; no result is pending.
module rational_reduce (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rr_pkg::rr_in_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rr_pkg::rr_out_t out_data_o
);

  localparam int W = rr_pkg::DATA_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EUC   = 3'd1;
  localparam logic [2:0] S_EWAIT = 3'd2;
  localparam logic [2:0] S_NDIV  = 3'd3;
  localparam logic [2:0] S_NWAIT = 3'd4;
  localparam logic [2:0] S_DDIV  = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]      state_q, state_d;
  logic            out_valid_q, out_valid_d;
  rr_pkg::rr_out_t out_data_q, out_data_d;

  logic [W-1:0] x_q, x_d, y_q, y_d;
  logic [W-1:0] mn_q, mn_d, md_q, md_d;
  logic [W-1:0] qn_q, qn_d, qd_q, qd_d;
  logic         sdiff_q, sdiff_d;
  logic         zden_q, zden_d;

  logic         div_start;
  logic [W-1:0] div_a, div_b;
  logic         div_done;
  logic [W-1:0] div_quo, div_rem;

  logic [W-1:0] in_num, in_den;
  logic         neg;
  logic         ovf;
  logic         out_free;

  assign in_num = in_data_i.numerator;
  assign in_den = in_data_i.denominator;

  rr_divider #(
    .WIDTH (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // result sign and range check
  assign neg      = sdiff_q && (qn_q != '0);
  assign ovf      = qd_q[W-1] ||
                    (neg ? (qn_q > {1'b1, {(W-1){1'b0}}}) : qn_q[W-1]);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    mn_d        = mn_q;
    md_d        = md_q;
    qn_d        = qn_q;
    qd_d        = qd_q;
    sdiff_d     = sdiff_q;
    zden_d      = zden_q;
    div_start   = 1'b0;
    div_a       = x_q;
    div_b       = y_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mn_d    = in_num[W-1] ? (~in_num + W'(1)) : in_num;
          md_d    = in_den[W-1] ? (~in_den + W'(1)) : in_den;
          x_d     = mn_d;
          y_d     = md_d;
          sdiff_d = in_num[W-1] ^ in_den[W-1];
          zden_d  = (in_den == '0);
          state_d = zden_d ? S_FIN : S_EUC;
        end
      end
      S_EUC: begin
        if (y_q == '0) begin
          state_d = S_NDIV;
        end else begin
          div_start = 1'b1;
          state_d   = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (div_done) begin
          x_d     = y_q;
          y_d     = div_rem;
          state_d = S_EUC;
        end
      end
      S_NDIV: begin
        div_start = 1'b1;
        div_a     = mn_q;
        div_b     = x_q;
        state_d   = S_NWAIT;
      end
      S_NWAIT: begin
        if (div_done) begin
          qn_d    = div_quo;
          state_d = S_DDIV;
        end
      end
      S_DDIV: begin
        div_start = 1'b1;
        div_a     = md_q;
        div_b     = x_q;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          qd_d    = div_quo;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d.reduced_numerator   = '0;
          out_data_d.reduced_denominator = '0;
          if (zden_q) begin
            out_data_d.status = rr_pkg::ST_ZERO_DEN;
          end else if (ovf) begin
            out_data_d.status = rr_pkg::ST_OVERFLOW;
          end else begin
            out_data_d.status              = rr_pkg::ST_OK;
            out_data_d.reduced_numerator   = neg ? (~qn_q + W'(1)) : qn_q;
            out_data_d.reduced_denominator = qd_q[W-2:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    mn_q       <= mn_d;
    md_q       <= md_d;
    qn_q       <= qn_d;
    qd_q       <= qd_d;
    sdiff_q    <= sdiff_d;
    zden_q     <= zden_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/rr_divider.sv
module rr_divider #(
  parameter int WIDTH = rr_pkg::DATA_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int CntW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // one restoring step: shift in next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = !diff[WIDTH];

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_WIDTH = rr_pkg::DATA_WIDTH;

  localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = ~VAL_MIN;
  localparam int RANDOM_ITEMS = 1280;
  localparam int DRAIN_CYCLES = 2000;

  // one pending fraction, optionally held back until the block has drained
  typedef struct {
    rr_pkg::rr_in_t frac;
    bit             wait_idle;
  } frac_req_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  rr_pkg::rr_in_t  in_data;
  logic            out_valid;
  logic            out_stall;
  rr_pkg::rr_out_t out_data;

  frac_req_t       frac_q[$];
  rr_pkg::rr_out_t reduced_q[$];

  int  send_gap;
  int  stall_left;
  bit  send_calm;
  bit  recv_calm;
  int  sent_cnt;
  int  ok_cnt;
  int  zero_den_cnt;
  int  overflow_cnt;
  int  mismatch_cnt;

  rational_reduce i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // lowest terms with the sign carried by the numerator
  function automatic rr_pkg::rr_out_t reduce_fraction(rr_pkg::rr_in_t frac);
    logic [63:0]     mask;
    logic [63:0]     half;
    logic [63:0]     num_bits;
    logic [63:0]     den_bits;
    logic [63:0]     mag_num;
    logic [63:0]     mag_den;
    logic [63:0]     x;
    logic [63:0]     y;
    logic [63:0]     r;
    logic [63:0]     qn;
    logic [63:0]     qd;
    logic            neg;
    rr_pkg::rr_out_t res;
    mask = {64{1'b1}} >> (64 - DATA_WIDTH);
    half = 64'd1 << (DATA_WIDTH - 1);
    num_bits = '0;
    den_bits = '0;
    num_bits[DATA_WIDTH-1:0] = frac.numerator;
    den_bits[DATA_WIDTH-1:0] = frac.denominator;
    res = '0;
    if (den_bits == 64'd0) begin
      res.status = rr_pkg::ST_ZERO_DEN;
      return res;
    end
    mag_num = num_bits[DATA_WIDTH-1] ? ((64'd0 - num_bits) & mask) : num_bits;
    mag_den = den_bits[DATA_WIDTH-1] ? ((64'd0 - den_bits) & mask) : den_bits;
    // euclid on magnitudes
    x = mag_num;
    y = mag_den;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    qn = mag_num / x;
    qd = mag_den / x;
    neg = (num_bits[DATA_WIDTH-1] != den_bits[DATA_WIDTH-1]) && (qn != 64'd0);
    if (qd > half - 64'd1 || (neg ? qn > half : qn > half - 64'd1)) begin
      res.status = rr_pkg::ST_OVERFLOW;
      return res;
    end
    x = neg ? (64'd0 - qn) : qn;
    res.reduced_numerator   = x[DATA_WIDTH-1:0];
    res.reduced_denominator = qd[DATA_WIDTH-2:0];
    res.status              = rr_pkg::ST_OK;
    return res;
  endfunction

  // idle length: mostly short, a few long, none in a calm stretch
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // edge values and powers of two with either sign
  function automatic logic signed [DATA_WIDTH-1:0] corner_value();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 6))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2: v = '0;
      3: v = 1;
      4: v = -1;
      5: v = VAL_MIN + 1;
      default: begin
        v = 1;
        v = v << $urandom_range(0, DATA_WIDTH - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic add_frac(input logic signed [DATA_WIDTH-1:0] num,
                          input logic signed [DATA_WIDTH-1:0] den,
                          input bit wait_idle);
    frac_req_t req;
    req.frac.numerator   = num;
    req.frac.denominator = den;
    req.wait_idle        = wait_idle;
    frac_q.push_back(req);
  endtask

  // driver: presents queued fractions, records the expected reduction per transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic           accepted;
    logic           next_valid;
    rr_pkg::rr_in_t next_data;
    frac_req_t      req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap  = 0;
      send_calm = 1'b0;
      sent_cnt  = 0;
    end else begin
      accepted = in_valid && !in_stall;
      if (accepted) begin
        reduced_q.push_back(reduce_fraction(in_data));
        sent_cnt++;
      end
      next_valid = in_valid && !accepted;
      next_data  = in_data;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (frac_q.size() != 0 &&
                     !(frac_q[0].wait_idle && reduced_q.size() != 0)) begin
          req        = frac_q.pop_front();
          next_data  = req.frac;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // monitor: random stall, field-by-field check of each result transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    logic            got;
    logic            next_stall;
    rr_pkg::rr_out_t want;
    int              n;
    if (!rst_ni) begin
      out_stall   <= 1'b0;
      stall_left   = 0;
      recv_calm    = 1'b0;
      ok_cnt       = 0;
      zero_den_cnt = 0;
      overflow_cnt = 0;
      mismatch_cnt = 0;
    end else begin
      got = out_valid && !out_stall;
      if (got) begin
        case (out_data.status)
          rr_pkg::ST_OK:       ok_cnt++;
          rr_pkg::ST_ZERO_DEN: zero_den_cnt++;
          rr_pkg::ST_OVERFLOW: overflow_cnt++;
          default: ;
        endcase
        if (reduced_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with nothing expected: %0d / %0d status %0d", $realtime,
                     out_data.reduced_numerator, out_data.reduced_denominator,
                     out_data.status);
        end else begin
          want = reduced_q.pop_front();
          if (out_data.reduced_numerator !== want.reduced_numerator ||
              out_data.reduced_denominator !== want.reduced_denominator ||
              out_data.status !== want.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: expected %0d / %0d status %0d, got %0d / %0d status %0d",
                       $realtime, want.reduced_numerator, want.reduced_denominator,
                       want.status, out_data.reduced_numerator,
                       out_data.reduced_denominator, out_data.status);
          end
        end
      end
      // stall either follows a transfer or starts now and then on its own
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (got || $urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        n = pick_gap(recv_calm);
        next_stall = (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // stimulus, reset and end of run
  initial begin : main_proc
    logic signed [DATA_WIDTH-1:0] num;
    logic signed [DATA_WIDTH-1:0] den;
    int unsigned g;
    int unsigned p;
    int unsigned q;
    bit          wait_idle;

    rst_ni = 1'b0;

    // directed: zero denominator, zero numerator, signs, range edges, longest euclid
    add_frac(0, 0, 1'b0);
    add_frac(5, 0, 1'b0);
    add_frac(VAL_MIN, 0, 1'b0);
    add_frac(0, 5, 1'b0);
    add_frac(0, -7, 1'b0);
    add_frac(0, VAL_MIN, 1'b0);
    add_frac(6, 4, 1'b0);
    add_frac(-6, 4, 1'b0);
    add_frac(6, -4, 1'b0);
    add_frac(-6, -4, 1'b0);
    add_frac(12, 18, 1'b0);
    add_frac(1000000, -250, 1'b0);
    add_frac(VAL_MAX, 1, 1'b0);
    add_frac(VAL_MIN, 1, 1'b0);
    add_frac(VAL_MIN, -1, 1'b0);
    add_frac(1, VAL_MIN, 1'b0);
    add_frac(-1, VAL_MIN, 1'b0);
    add_frac(VAL_MIN, VAL_MIN, 1'b0);
    add_frac(VAL_MIN, 2, 1'b0);
    add_frac(VAL_MAX, VAL_MAX, 1'b0);
    add_frac(VAL_MAX, VAL_MIN, 1'b0);
    add_frac(VAL_MIN + 1, -1, 1'b0);
    add_frac(1836311903, 1134903170, 1'b0);
    add_frac(-1134903170, 1836311903, 1'b0);

    // random: plain, with real common factors, corner values, unit or zero denominators, small values
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      wait_idle = (i == 0) || (i == RANDOM_ITEMS / 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          num = $urandom;
          den = $urandom;
        end
        4, 5, 6: begin
          g = $urandom_range(1, 65535);
          p = $urandom_range(0, 32767);
          q = $urandom_range(1, 32767);
          num = p * g;
          den = q * g;
          if ($urandom_range(0, 1) == 1) num = -num;
          if ($urandom_range(0, 1) == 1) den = -den;
        end
        7: begin
          num = corner_value();
          den = corner_value();
        end
        8: begin
          num = $urandom;
          case ($urandom_range(0, 2))
            0: den = 0;
            1: den = 1;
            default: den = -1;
          endcase
        end
        default: begin
          num = $urandom_range(0, 40);
          den = $urandom_range(0, 40);
          num = num - 20;
          den = den - 20;
        end
      endcase
      add_frac(num, den, wait_idle);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (frac_q.size() != 0 || in_valid) @(posedge clk_i);
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d fractions: %0d reduced, %0d with zero denominator, %0d out of range",
             sent_cnt, ok_cnt, zero_den_cnt, overflow_cnt);
    $display("Random stalls on both channels; %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog_proc
    #(64'd200_000_000);
    $display("Timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

endmodule
